FILE: rtl/lwr_tpe_pkg.sv
// ----------------------------------------------------------------------------
// lwr_tpe_pkg
// Types, constants and the rounding function shared by the LWR PRF evaluator.
// ----------------------------------------------------------------------------
package lwr_tpe_pkg;

   localparam int unsigned ELEM_W     = 32;
   localparam int unsigned PRF_W      = 31;
   localparam int unsigned SUM_W      = 31;
   localparam int unsigned RND_W      = 32;
   localparam int unsigned DOT_MAX_W  = 64;
   localparam int unsigned KEY_BITS_W = 7;
   localparam int unsigned LOG_Q_W    = 6;
   localparam int unsigned LOG_S_W    = 5;
   localparam int unsigned CSR_DATA_W = 6;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned OUT_DEPTH  = 8;
   localparam int unsigned PTR_W      = $clog2(OUT_DEPTH);
   localparam int unsigned OCC_W      = $clog2(OUT_DEPTH + 1);
   localparam int unsigned BUSY_W     = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EVAL_MODE = 2'd0,
      CSR_LOG_Q     = 2'd1,
      CSR_LOG_Q1    = 2'd2,
      CSR_LOG_P     = 2'd3
   } csr_index_type;

   localparam logic MODE_THRESHOLD = 1'b0;
   localparam logic MODE_DIRECT    = 1'b1;

   localparam logic [LOG_Q_W-1:0] RST_LOG_Q  = 6'd32;
   localparam logic [LOG_S_W-1:0] RST_LOG_Q1 = 5'd28;
   localparam logic [LOG_S_W-1:0] RST_LOG_P  = 5'd10;

   typedef struct packed {
      logic                  eval_mode;
      logic [KEY_BITS_W-1:0] key_bits;
      logic [LOG_S_W-1:0]    log_q1;
      logic [LOG_S_W-1:0]    log_p;
   } cfg_type;

   typedef struct packed {
      logic                 valid;
      logic                 last_share;
      logic [DOT_MAX_W-1:0] dot;
   } dot_type;

   // drop the low (from_bits - to_bits) bits, add back the highest dropped bit
   function automatic logic [RND_W-1:0] round_bits(input logic [DOT_MAX_W-1:0]  x,
                                                   input logic [KEY_BITS_W-1:0] from_bits,
                                                   input logic [KEY_BITS_W-1:0] to_bits);
      logic [KEY_BITS_W-1:0] d;
      logic [DOT_MAX_W-1:0]  sh;
      logic                  half;
      logic [5:0]            hidx;
      d    = from_bits - to_bits;
      sh   = x >> d;
      hidx = 6'(d - 7'd1);
      half = x[hidx];
      if (to_bits >= from_bits) begin
         return x[RND_W-1:0];
      end
      return sh[RND_W-1:0] + {{(RND_W-1){1'b0}}, half};
   endfunction

endpackage

FILE: rtl/lwr_tpe_req_if.sv
// ----------------------------------------------------------------------------
// lwr_tpe_req_if
// Request channel: one vector element and key-share element per beat.
// ----------------------------------------------------------------------------
interface lwr_tpe_req_if;
   logic                             valid;
   logic                             ready;
   logic [lwr_tpe_pkg::ELEM_W-1:0]   vec_elem;
   logic [lwr_tpe_pkg::ELEM_W-1:0]   share_elem;
   logic                             last_elem;
   logic                             last_share;

   modport source (output valid, vec_elem, share_elem, last_elem, last_share, input ready);
   modport sink   (input valid, vec_elem, share_elem, last_elem, last_share, output ready);
endinterface

FILE: rtl/lwr_tpe_rsp_if.sv
// ----------------------------------------------------------------------------
// lwr_tpe_rsp_if
// Response channel: one rounded PRF value per beat.
// ----------------------------------------------------------------------------
interface lwr_tpe_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [lwr_tpe_pkg::PRF_W-1:0]   prf_value;

   modport source (output valid, prf_value, input ready);
   modport sink   (input valid, prf_value, output ready);
endinterface

FILE: rtl/lwr_tpe_mac.sv
// ----------------------------------------------------------------------------
// lwr_tpe_mac
// Input register, 32x32 multiply and inner-product accumulate mod 2^key_bits.
// ----------------------------------------------------------------------------
module lwr_tpe_mac #(
   parameter int unsigned Q_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [lwr_tpe_pkg::KEY_BITS_W-1:0]  key_bits,
   input  logic                                in_accept,
   input  logic [lwr_tpe_pkg::ELEM_W-1:0]      in_vec_elem,
   input  logic [lwr_tpe_pkg::ELEM_W-1:0]      in_share_elem,
   input  logic                                in_last_elem,
   input  logic                                in_last_share,
   output lwr_tpe_pkg::dot_type                dot_out,
   output logic [lwr_tpe_pkg::BUSY_W-1:0]      busy_count
);

   logic                               s1_valid_ff;
   logic [lwr_tpe_pkg::ELEM_W-1:0]     vec_ff;
   logic [lwr_tpe_pkg::ELEM_W-1:0]     share_ff;
   logic                               s1_last_elem_ff;
   logic                               s1_last_share_ff;

   logic                               s2_valid_ff;
   logic [2*lwr_tpe_pkg::ELEM_W-1:0]   prod_full;
   logic [Q_BITS-1:0]                  prod_ff;
   logic                               s2_last_elem_ff;
   logic                               s2_last_share_ff;

   logic [Q_BITS-1:0]                  key_mask;
   logic [Q_BITS-1:0]                  acc_sum;
   logic [Q_BITS-1:0]                  dot_acc_ff;
   logic [Q_BITS-1:0]                  dot_acc_in;
   logic                               s3_valid_ff;
   logic                               s3_last_share_ff;
   logic [Q_BITS-1:0]                  dot_ff;

   assign prod_full = vec_ff * share_ff;

   always_comb begin
      for (int i = 0; i < Q_BITS; i++) begin
         key_mask[i] = (lwr_tpe_pkg::KEY_BITS_W'(i) < key_bits);
      end
   end

   assign acc_sum = (dot_acc_ff + prod_ff) & key_mask;

   always_comb begin
      dot_acc_in = dot_acc_ff;
      if (s2_valid_ff) begin
         dot_acc_in = s2_last_elem_ff ? '0 : acc_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         dot_acc_ff  <= '0;
      end else begin
         s1_valid_ff <= in_accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff & s2_last_elem_ff;
         dot_acc_ff  <= dot_acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         vec_ff           <= in_vec_elem;
         share_ff         <= in_share_elem;
         s1_last_elem_ff  <= in_last_elem;
         s1_last_share_ff <= in_last_share;
      end
      if (s1_valid_ff) begin
         prod_ff          <= prod_full[Q_BITS-1:0];
         s2_last_elem_ff  <= s1_last_elem_ff;
         s2_last_share_ff <= s1_last_share_ff;
      end
      if (s2_valid_ff) begin
         dot_ff           <= acc_sum;
         s3_last_share_ff <= s2_last_share_ff;
      end
   end

   assign dot_out.valid      = s3_valid_ff;
   assign dot_out.last_share = s3_last_share_ff;
   assign dot_out.dot        = lwr_tpe_pkg::DOT_MAX_W'(dot_ff);

   assign busy_count = lwr_tpe_pkg::BUSY_W'({1'b0, s1_valid_ff} + {1'b0, s2_valid_ff}
                                            + {1'b0, s3_valid_ff});

endmodule

FILE: rtl/lwr_tpe_combine.sv
// ----------------------------------------------------------------------------
// lwr_tpe_combine
// Round finished inner products; in threshold mode, combine shares and round the total.
// ----------------------------------------------------------------------------
module lwr_tpe_combine (
   input  logic                              clock,
   input  logic                              reset,
   input  lwr_tpe_pkg::cfg_type              cfg,
   input  lwr_tpe_pkg::dot_type              dot_in,
   output logic                              push_valid,
   output logic [lwr_tpe_pkg::PRF_W-1:0]     push_data,
   output logic [lwr_tpe_pkg::BUSY_W-1:0]    busy_count
);

   logic [lwr_tpe_pkg::KEY_BITS_W-1:0]  round_to;
   logic [lwr_tpe_pkg::RND_W-1:0]       r_in;
   logic                                s4_valid_ff;
   logic [lwr_tpe_pkg::RND_W-1:0]       r_ff;
   logic                                s4_last_share_ff;
   logic                                s4_direct_ff;

   logic [lwr_tpe_pkg::SUM_W-1:0]       q1_mask;
   logic [lwr_tpe_pkg::SUM_W-1:0]       r_low;
   logic [lwr_tpe_pkg::SUM_W-1:0]       new_sum;
   logic [lwr_tpe_pkg::SUM_W-1:0]       share_sum_ff;
   logic [lwr_tpe_pkg::SUM_W-1:0]       share_sum_in;
   logic                                first_share_ff;
   logic                                first_share_in;
   logic                                s5_valid_in;
   logic                                s5_valid_ff;
   logic [lwr_tpe_pkg::SUM_W-1:0]       val_in;
   logic [lwr_tpe_pkg::SUM_W-1:0]       val_ff;
   logic                                need_round_in;
   logic                                need_round_ff;
   logic [lwr_tpe_pkg::RND_W-1:0]       final_round;

   assign round_to = (cfg.eval_mode == lwr_tpe_pkg::MODE_DIRECT) ?
                     {2'b00, cfg.log_p} : {2'b00, cfg.log_q1};
   assign r_in     = lwr_tpe_pkg::round_bits(dot_in.dot, cfg.key_bits, round_to);

   always_comb begin
      for (int i = 0; i < lwr_tpe_pkg::SUM_W; i++) begin
         q1_mask[i] = (lwr_tpe_pkg::LOG_S_W'(i) < cfg.log_q1);
      end
   end

   assign r_low   = r_ff[lwr_tpe_pkg::SUM_W-1:0];
   assign new_sum = (first_share_ff ? (share_sum_ff + r_low) : (share_sum_ff - r_low)) & q1_mask;

   always_comb begin
      share_sum_in   = share_sum_ff;
      first_share_in = first_share_ff;
      s5_valid_in    = 1'b0;
      val_in         = r_low;
      need_round_in  = 1'b0;
      if (s4_valid_ff) begin
         if (s4_direct_ff) begin
            s5_valid_in = 1'b1;
         end else begin
            share_sum_in   = s4_last_share_ff ? '0 : new_sum;
            first_share_in = s4_last_share_ff;
            s5_valid_in    = s4_last_share_ff;
            val_in         = new_sum;
            need_round_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff    <= 1'b0;
         s5_valid_ff    <= 1'b0;
         share_sum_ff   <= '0;
         first_share_ff <= 1'b1;
      end else begin
         s4_valid_ff    <= dot_in.valid;
         s5_valid_ff    <= s5_valid_in;
         share_sum_ff   <= share_sum_in;
         first_share_ff <= first_share_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dot_in.valid) begin
         r_ff             <= r_in;
         s4_last_share_ff <= dot_in.last_share;
         s4_direct_ff     <= cfg.eval_mode;
      end
      if (s4_valid_ff) begin
         val_ff        <= val_in;
         need_round_ff <= need_round_in;
      end
   end

   assign final_round = lwr_tpe_pkg::round_bits(lwr_tpe_pkg::DOT_MAX_W'(val_ff),
                                                {2'b00, cfg.log_q1}, {2'b00, cfg.log_p});

   assign push_valid = s5_valid_ff;
   assign push_data  = need_round_ff ? final_round[lwr_tpe_pkg::PRF_W-1:0] : val_ff;
   assign busy_count = lwr_tpe_pkg::BUSY_W'({1'b0, s4_valid_ff} + {1'b0, s5_valid_ff});

endmodule

FILE: rtl/lwr_tpe_fifo.sv
// ----------------------------------------------------------------------------
// lwr_tpe_fifo
// Result queue that decouples the pipeline from response back-pressure.
// ----------------------------------------------------------------------------
module lwr_tpe_fifo (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push_valid,
   input  logic [lwr_tpe_pkg::PRF_W-1:0]   push_data,
   lwr_tpe_rsp_if.source                   rsp_chan,
   output logic [lwr_tpe_pkg::OCC_W-1:0]   count
);

   logic [lwr_tpe_pkg::PRF_W-1:0]  mem [lwr_tpe_pkg::OUT_DEPTH];
   logic [lwr_tpe_pkg::PTR_W-1:0]  wr_ptr_ff;
   logic [lwr_tpe_pkg::PTR_W-1:0]  rd_ptr_ff;
   logic [lwr_tpe_pkg::OCC_W-1:0]  count_ff;
   logic [lwr_tpe_pkg::OCC_W-1:0]  count_in;
   logic                           pop;

   assign pop = rsp_chan.valid & rsp_chan.ready;

   always_comb begin
      count_in = count_ff;
      if (push_valid & ~pop) begin
         count_in = count_ff + 1'b1;
      end else if (~push_valid & pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   assign rsp_chan.valid     = (count_ff != '0);
   assign rsp_chan.prf_value = mem[rd_ptr_ff];
   assign count              = count_ff;

endmodule

FILE: rtl/lwr_threshold_prf_eval.sv
// ----------------------------------------------------------------------------
// lwr_threshold_prf_eval
// Learning-with-rounding PRF evaluator, direct or threshold share combination.
// Latency: a result passes MAC stages s1-s3, combine stages s4-s5 and the
//   queue before it is valid on rsp. Throughput: one element per cycle;
//   the 8-entry result queue sets req ready from queue fill plus items in flight.
// Reset: clears accumulators, share state and queue; registers take defaults.
// ----------------------------------------------------------------------------
module lwr_threshold_prf_eval #(
   parameter int unsigned Q_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   lwr_tpe_req_if.sink                          req_chan,
   lwr_tpe_rsp_if.source                        rsp_chan,
   input  logic                                 csr_wr_en,
   input  logic [lwr_tpe_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lwr_tpe_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic                                   eval_mode_ff;
   logic [lwr_tpe_pkg::LOG_Q_W-1:0]        log_q_ff;
   logic [lwr_tpe_pkg::LOG_S_W-1:0]        log_q1_ff;
   logic [lwr_tpe_pkg::LOG_S_W-1:0]        log_p_ff;
   logic [lwr_tpe_pkg::KEY_BITS_W-1:0]     log_q_ext;
   lwr_tpe_pkg::cfg_type                   cfg;
   lwr_tpe_pkg::dot_type                   dot_beat;
   logic                                   req_accept;
   logic [lwr_tpe_pkg::BUSY_W-1:0]         mac_busy;
   logic [lwr_tpe_pkg::BUSY_W-1:0]         comb_busy;
   logic [lwr_tpe_pkg::OCC_W-1:0]          fifo_count;
   logic [lwr_tpe_pkg::OCC_W-1:0]          occupancy;
   logic                                   push_valid;
   logic [lwr_tpe_pkg::PRF_W-1:0]          push_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         eval_mode_ff <= lwr_tpe_pkg::MODE_THRESHOLD;
         log_q_ff     <= lwr_tpe_pkg::RST_LOG_Q;
         log_q1_ff    <= lwr_tpe_pkg::RST_LOG_Q1;
         log_p_ff     <= lwr_tpe_pkg::RST_LOG_P;
      end else if (csr_wr_en) begin
         case (lwr_tpe_pkg::csr_index_type'(csr_index))
            lwr_tpe_pkg::CSR_EVAL_MODE: eval_mode_ff <= csr_wdata[0];
            lwr_tpe_pkg::CSR_LOG_Q:     log_q_ff     <= csr_wdata;
            lwr_tpe_pkg::CSR_LOG_Q1:    log_q1_ff    <= csr_wdata[lwr_tpe_pkg::LOG_S_W-1:0];
            lwr_tpe_pkg::CSR_LOG_P:     log_p_ff     <= csr_wdata[lwr_tpe_pkg::LOG_S_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign log_q_ext     = {1'b0, log_q_ff};
   assign cfg.eval_mode = eval_mode_ff;
   assign cfg.key_bits  = (log_q_ext > lwr_tpe_pkg::KEY_BITS_W'(Q_BITS)) ?
                          lwr_tpe_pkg::KEY_BITS_W'(Q_BITS) : log_q_ext;
   assign cfg.log_q1    = log_q1_ff;
   assign cfg.log_p     = log_p_ff;

   assign occupancy      = fifo_count + lwr_tpe_pkg::OCC_W'(mac_busy)
                           + lwr_tpe_pkg::OCC_W'(comb_busy);
   assign req_chan.ready = (occupancy < lwr_tpe_pkg::OCC_W'(lwr_tpe_pkg::OUT_DEPTH));
   assign req_accept     = req_chan.valid & req_chan.ready;

   lwr_tpe_mac #(
      .Q_BITS (Q_BITS)
   ) u_mac (
      .clock         (clock),
      .reset         (reset),
      .key_bits      (cfg.key_bits),
      .in_accept     (req_accept),
      .in_vec_elem   (req_chan.vec_elem),
      .in_share_elem (req_chan.share_elem),
      .in_last_elem  (req_chan.last_elem),
      .in_last_share (req_chan.last_share),
      .dot_out       (dot_beat),
      .busy_count    (mac_busy)
   );

   lwr_tpe_combine u_combine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .dot_in     (dot_beat),
      .push_valid (push_valid),
      .push_data  (push_data),
      .busy_count (comb_busy)
   );

   lwr_tpe_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .rsp_chan   (rsp_chan),
      .count      (fifo_count)
   );

endmodule
